// ===== src/refcounted_slot_allocator_defines.svh =====
// assertion helpers for the slot allocator checker
// expects clk and arst_n in scope at the point of use
`ifndef REFCOUNTED_SLOT_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define RSA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slot allocator check failed");

// next-cycle implication
`define RSA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slot allocator check failed");

`endif

// ===== src/rsa_pkg.sv =====
`timescale 1ns / 1ps

package rsa_pkg;

	localparam int SLOTS_DEF      = 256;
	localparam int COUNT_BITS_DEF = 16;

	localparam int OP_W     = 2;
	localparam int HANDLE_W = 8;
	localparam int SLOT_W   = 8;
	localparam int REFCNT_W = 16;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_REF   = 2'd1;
	localparam logic [OP_W-1:0] OP_REL   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SAT    = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [HANDLE_W-1:0] handle;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [REFCNT_W-1:0] ref_count;
		logic                freed;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} sts_t;

endpackage

// ===== src/refcounted_slot_allocator.sv =====
`timescale 1ns / 1ps

// channel   dir   payload          handshake
// req       in    rsa_pkg::req_t   req_valid / req_stall
// rsp       out   rsa_pkg::rsp_t   rsp_valid / rsp_stall
//
// for each request, the accept cycle starts registered reads of the
// free stack and count memories, the execute cycle writes them back and loads
// the output register; the next request is taken in the cycle after that
// after reset a clearing pass fills the free stack and zeroes
// the counts, with req_stall high throughout
// a stalled response holds the execute cycle until the output register frees

module refcounted_slot_allocator #(
	parameter int SLOTS      = rsa_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rsa_pkg::rsp_t rsp
);

	rsa_pkg::cmd_t cmd;
	rsa_pkg::sts_t sts;

	rsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	rsa_dpath #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

// ===== src/rsa_ctrl.sv =====
`timescale 1ns / 1ps

module rsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  rsa_pkg::sts_t sts,
	output logic          req_stall,
	output rsa_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		CLEAR,
		IDLE,
		EXEC
	} state_t;

	state_t state_q;
	logic   stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			stall_q <= 1'b1;
		end else begin
			case (state_q)
				CLEAR: begin
					if (sts.clear_last) begin
						state_q <= IDLE;
						stall_q <= 1'b0;
					end
				end
				IDLE: begin
					if (req_valid) begin
						state_q <= EXEC;
						stall_q <= 1'b1;
					end
				end
				EXEC: begin
					// wait for the output register to free up
					if (sts.out_free) begin
						state_q <= IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= CLEAR;
					stall_q <= 1'b1;
				end
			endcase
		end
	end

	assign req_stall  = stall_q;
	assign cmd.clear  = (state_q == CLEAR);
	assign cmd.accept = (state_q == IDLE) && req_valid && !stall_q;
	assign cmd.exec   = (state_q == EXEC) && sts.out_free;

endmodule

// ===== src/rsa_dpath.sv =====
`timescale 1ns / 1ps

module rsa_dpath #(
	parameter int SLOTS      = rsa_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rsa_pkg::cmd_t cmd,
	output rsa_pkg::sts_t sts,
	input  rsa_pkg::req_t req,
	output rsa_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_stall
);

	localparam int SW  = $clog2(SLOTS);
	localparam int FCW = $clog2(SLOTS + 1);
	localparam int CB  = COUNT_BITS;

	logic [SW-1:0] stack_mem [SLOTS];
	logic [CB-1:0] cnt_mem   [SLOTS];

	logic [SW-1:0]  clr_q;
	logic [FCW-1:0] fc_q;
	logic [FCW-1:0] fc_m1;

	logic [rsa_pkg::OP_W-1:0]     op_q;
	logic [rsa_pkg::HANDLE_W-1:0] handle_q;
	logic                         inrange_q;
	logic [SW-1:0]                stk_rd_q;
	logic [CB-1:0]                cnt_rd_q;

	rsa_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	rsa_pkg::rsp_t res;
	logic          cw_en;
	logic [SW-1:0] cw_addr;
	logic [CB-1:0] cw_data;
	logic          sw_en;
	logic [SW-1:0] sw_addr;
	logic [SW-1:0] sw_data;
	logic          fc_dec;
	logic          fc_inc;
	logic [CB-1:0] cnt_dec;

	assign fc_m1           = fc_q - FCW'(1);
	assign cnt_dec         = cnt_rd_q - CB'(1);
	assign sts.clear_last  = (clr_q == SW'(SLOTS - 1));
	assign sts.out_free    = !rsp_valid_q || !rsp_stall;

	// clearing sweep pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear && !sts.clear_last) begin
			clr_q <= clr_q + SW'(1);
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= req.op;
			handle_q  <= req.handle;
			inrange_q <= (32'(req.handle) < 32'(SLOTS));
		end
	end

	always_comb begin
		res.slot      = handle_q;
		res.ref_count = '0;
		res.freed     = 1'b0;
		res.status    = rsa_pkg::ST_OK;
		cw_en         = 1'b0;
		cw_addr       = SW'(handle_q);
		cw_data       = '0;
		sw_en         = 1'b0;
		sw_addr       = fc_q[SW-1:0];
		sw_data       = SW'(handle_q);
		fc_dec        = 1'b0;
		fc_inc        = 1'b0;
		case (op_q)
			rsa_pkg::OP_ALLOC: begin
				if (fc_q == '0) begin
					res.slot   = '0;
					res.status = rsa_pkg::ST_EMPTY;
				end else begin
					res.slot      = rsa_pkg::SLOT_W'(stk_rd_q);
					res.ref_count = rsa_pkg::REFCNT_W'(1);
					cw_en         = 1'b1;
					cw_addr       = stk_rd_q;
					cw_data       = CB'(1);
					fc_dec        = 1'b1;
				end
			end
			rsa_pkg::OP_REF: begin
				if (!inrange_q || cnt_rd_q == '0) begin
					res.status = rsa_pkg::ST_UNUSED;
				end else if (cnt_rd_q == {CB{1'b1}}) begin
					res.ref_count = rsa_pkg::REFCNT_W'(cnt_rd_q);
					res.status    = rsa_pkg::ST_SAT;
				end else begin
					res.ref_count = rsa_pkg::REFCNT_W'(cnt_rd_q + CB'(1));
					cw_en         = 1'b1;
					cw_data       = cnt_rd_q + CB'(1);
				end
			end
			rsa_pkg::OP_REL: begin
				if (!inrange_q || cnt_rd_q == '0) begin
					res.status = rsa_pkg::ST_UNUSED;
				end else begin
					res.ref_count = rsa_pkg::REFCNT_W'(cnt_dec);
					cw_en         = 1'b1;
					cw_data       = cnt_dec;
					// last reference gone: back onto the free stack unless it is full
					if (cnt_dec == '0 && fc_q != FCW'(SLOTS)) begin
						sw_en     = 1'b1;
						fc_inc    = 1'b1;
						res.freed = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= FCW'(SLOTS);
		end else if (cmd.exec) begin
			if (fc_dec) begin
				fc_q <= fc_m1;
			end else if (fc_inc) begin
				fc_q <= fc_q + FCW'(1);
			end
		end
	end

	// free stack memory
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			stack_mem[clr_q] <= SW'(SLOTS - 1) - clr_q;
		end else if (cmd.exec && sw_en) begin
			stack_mem[sw_addr] <= sw_data;
		end
		if (cmd.accept) begin
			stk_rd_q <= stack_mem[fc_m1[SW-1:0]];
		end
	end

	// reference count memory
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			cnt_mem[clr_q] <= '0;
		end else if (cmd.exec && cw_en) begin
			cnt_mem[cw_addr] <= cw_data;
		end
		if (cmd.accept) begin
			cnt_rd_q <= cnt_mem[SW'(req.handle)];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= res;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== src/rsa_chk.sv =====
`timescale 1ns / 1ps

`include "refcounted_slot_allocator_defines.svh"

module rsa_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input rsa_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input rsa_pkg::rsp_t rsp
);

	// a stalled response stays put
	`RSA_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// one request in flight at a time
	`RSA_ASSERT_NXT(a_one_at_a_time, req_valid && !req_stall, req_stall)

	// with room at the output in the execute cycle, the response to an accepted request shows valid
	`RSA_ASSERT_NXT(a_rsp_latency, (req_valid && !req_stall) ##1 !(rsp_valid && rsp_stall), rsp_valid)

	// a freed slot always comes back with a zero count and ok status
	`RSA_ASSERT_IMP(a_freed_ok, rsp_valid && rsp.freed, rsp.status == rsa_pkg::ST_OK && rsp.ref_count == '0)

endmodule

bind refcounted_slot_allocator rsa_chk u_chk (.*);

// ===== tb/refcounted_slot_allocator_test.sv =====
`timescale 1ns / 1ps

module refcounted_slot_allocator_test;

	localparam int NSLOTS = rsa_pkg::SLOTS_DEF;
	localparam logic [rsa_pkg::REFCNT_W-1:0] COUNT_MAX = '1;
	localparam logic [rsa_pkg::OP_W-1:0] OP_UNDEF = 2'd3;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1300;
	localparam int SEGMENT_ITEMS = 100;
	localparam int DEPTH_REFS = 100;
	localparam int REPORT_LINES = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	rsa_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsa_pkg::rsp_t rsp;

	// allocator state as predicted from the accepted requests
	logic [rsa_pkg::SLOT_W-1:0] free_stack [NSLOTS];
	int free_cnt;
	logic [rsa_pkg::REFCNT_W-1:0] slot_refs [NSLOTS];
	rsa_pkg::rsp_t pending_rsps [$];
	rsa_pkg::rsp_t want;

	int mismatches = 0;
	int idle_cycles = 0;
	bit sender_gaps_on = 1'b1;
	bit stall_noise_on = 1'b1;
	bit hold_request = 1'b0;

	refcounted_slot_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reset_pool();
		for (int i = 0; i < NSLOTS; i++) begin
			free_stack[i] = rsa_pkg::SLOT_W'(NSLOTS - 1 - i);
			slot_refs[i] = '0;
		end
		free_cnt = NSLOTS;
	endfunction

	function automatic rsa_pkg::rsp_t apply_op(rsa_pkg::req_t r);
		rsa_pkg::rsp_t res;
		int s;
		res = '0;
		case (r.op)
			rsa_pkg::OP_ALLOC: begin
				if (free_cnt == 0) begin
					res.status = rsa_pkg::ST_EMPTY;
				end else begin
					free_cnt--;
					s = free_stack[free_cnt];
					slot_refs[s] = rsa_pkg::REFCNT_W'(1);
					res.slot = rsa_pkg::SLOT_W'(s);
					res.ref_count = rsa_pkg::REFCNT_W'(1);
					res.status = rsa_pkg::ST_OK;
				end
			end
			OP_UNDEF: begin
				res.slot = r.handle;
				res.status = rsa_pkg::ST_OK;
			end
			default: begin
				res.slot = r.handle;
				if (slot_refs[r.handle] == 0) begin
					res.status = rsa_pkg::ST_UNUSED;
				end else if (r.op == rsa_pkg::OP_REF) begin
					if (slot_refs[r.handle] == COUNT_MAX) begin
						res.status = rsa_pkg::ST_SAT;
					end else begin
						slot_refs[r.handle]++;
						res.status = rsa_pkg::ST_OK;
					end
					res.ref_count = slot_refs[r.handle];
				end else begin
					slot_refs[r.handle]--;
					res.ref_count = slot_refs[r.handle];
					res.status = rsa_pkg::ST_OK;
					// last reference gone: slot goes back on top of the free stack
					if (slot_refs[r.handle] == 0 && free_cnt < NSLOTS) begin
						free_stack[free_cnt] = r.handle;
						free_cnt++;
						res.freed = 1'b1;
					end
				end
			end
		endcase
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// allocations or operations on live slots, weighted by alloc_bias, with some noise on random handles
	function automatic rsa_pkg::req_t pick_request(int alloc_bias);
		rsa_pkg::req_t r;
		int live [$];
		int roll;
		r.op = rsa_pkg::OP_ALLOC;
		r.handle = rsa_pkg::HANDLE_W'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			r.op = OP_UNDEF;
		end else if (roll < 10) begin
			r.op = $urandom_range(0, 1) ? rsa_pkg::OP_REF : rsa_pkg::OP_REL;
		end else if ($urandom_range(0, 99) >= alloc_bias) begin
			for (int i = 0; i < NSLOTS; i++)
				if (slot_refs[i] != 0)
					live.push_back(i);
			if (live.size() > 0) begin
				r.handle = rsa_pkg::HANDLE_W'(live[$urandom_range(0, live.size() - 1)]);
				r.op = ($urandom_range(0, 99) < 60) ? rsa_pkg::OP_REL : rsa_pkg::OP_REF;
			end
		end
		return r;
	endfunction

	task automatic send_request(input logic [rsa_pkg::OP_W-1:0] op,
			input logic [rsa_pkg::HANDLE_W-1:0] handle);
		rsa_pkg::req_t item;
		int gap;
		item.op = op;
		item.handle = handle;
		req <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		pending_rsps.push_back(apply_op(item));
		gap = sender_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(int alloc_bias);
		rsa_pkg::req_t r;
		r = pick_request(alloc_bias);
		send_request(r.op, r.handle);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsps.size() != 0);
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LINES)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic test_allocation_order();
		repeat (4) send_request(rsa_pkg::OP_ALLOC, rsa_pkg::HANDLE_W'($urandom_range(0, 255)));
	endtask

	task automatic test_reference_and_release();
		send_request(rsa_pkg::OP_REF, 8'd1);
		send_request(rsa_pkg::OP_REL, 8'd1);
		send_request(rsa_pkg::OP_REL, 8'd1);
		// slot 1 is free now
		send_request(rsa_pkg::OP_REL, 8'd1);
		send_request(rsa_pkg::OP_REF, 8'd1);
		send_request(rsa_pkg::OP_REF, 8'd255);
		send_request(rsa_pkg::OP_REL, 8'd255);
		send_request(OP_UNDEF, 8'd255);
		send_request(OP_UNDEF, 8'd0);
		send_request(OP_UNDEF, 8'hA5);
		send_request(rsa_pkg::OP_ALLOC, 8'd0);
		send_request(rsa_pkg::OP_ALLOC, 8'hFF);
	endtask

	task automatic test_pool_exhaustion();
		logic [rsa_pkg::HANDLE_W-1:0] victim;
		while (free_cnt > 0)
			send_request(rsa_pkg::OP_ALLOC, rsa_pkg::HANDLE_W'($urandom_range(0, 255)));
		repeat (3) send_request(rsa_pkg::OP_ALLOC, rsa_pkg::HANDLE_W'($urandom_range(0, 255)));
		victim = rsa_pkg::HANDLE_W'($urandom_range(0, 255));
		while (slot_refs[victim] != 1)
			victim = rsa_pkg::HANDLE_W'($urandom_range(0, 255));
		send_request(rsa_pkg::OP_REL, victim);
		send_request(rsa_pkg::OP_ALLOC, 8'd0);
		send_request(rsa_pkg::OP_ALLOC, 8'd0);
		// hand half the pool back for the random traffic
		for (int i = 0; i < NSLOTS; i += 2)
			if (slot_refs[i] == 1)
				send_request(rsa_pkg::OP_REL, rsa_pkg::HANDLE_W'(i));
	endtask

	task automatic test_backpressure();
		sender_gaps_on = 1'b0;
		hold_request = 1'b1;
		repeat (24) send_random(45);
		wait_drained();
		sender_gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int bias;
		for (int seg = 0; seg < RANDOM_ITEMS / SEGMENT_ITEMS; seg++) begin
			case (seg % 3)
				0: bias = 75;
				1: bias = 20;
				default: bias = 45;
			endcase
			sender_gaps_on = $urandom_range(0, 3) != 0;
			stall_noise_on = $urandom_range(0, 3) != 0;
			repeat (SEGMENT_ITEMS) send_random(bias);
			if (seg == 7)
				wait_drained();
		end
		sender_gaps_on = 1'b1;
		stall_noise_on = 1'b1;
	endtask

	task automatic test_reference_depth();
		int target;
		target = -1;
		for (int i = 0; i < NSLOTS; i++)
			if (target < 0 && slot_refs[i] != 0)
				target = i;
		if (target < 0) begin
			target = free_stack[free_cnt - 1];
			send_request(rsa_pkg::OP_ALLOC, 8'd0);
		end
		// deep count built up back to back, then taken down to zero
		sender_gaps_on = 1'b0;
		stall_noise_on = 1'b0;
		repeat (DEPTH_REFS) send_request(rsa_pkg::OP_REF, rsa_pkg::HANDLE_W'(target));
		sender_gaps_on = 1'b1;
		stall_noise_on = 1'b1;
		while (slot_refs[target] != 0)
			send_request(rsa_pkg::OP_REL, rsa_pkg::HANDLE_W'(target));
		send_request(rsa_pkg::OP_REL, rsa_pkg::HANDLE_W'(target));
		send_request(rsa_pkg::OP_REF, rsa_pkg::HANDLE_W'(target));
	endtask

	// receiver: random stall runs, plus one long hold-off on demand
	initial begin : rsp_side
		int stall_left;
		int run_left;
		rsp_stall = 1'b0;
		stall_left = 0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
				stall_left = 0;
				run_left = 0;
			end else if (!stall_noise_on) begin
				rsp_stall <= 1'b0;
			end else if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else if (run_left > 0) begin
				rsp_stall <= 1'b0;
				run_left--;
			end else begin
				run_left = $urandom_range(0, 12);
				stall_left = pick_gap();
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsps.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.slot !== want.slot)
					report_mismatch($sformatf("slot %0d, expected %0d", rsp.slot, want.slot));
				if (rsp.ref_count !== want.ref_count)
					report_mismatch($sformatf("ref_count %0d, expected %0d",
						rsp.ref_count, want.ref_count));
				if (rsp.freed !== want.freed)
					report_mismatch($sformatf("freed %b, expected %b", rsp.freed, want.freed));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, want.status));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("refcounted_slot_allocator test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		reset_pool();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_allocation_order();
		test_reference_and_release();
		test_pool_exhaustion();
		test_backpressure();
		test_random_traffic();
		test_reference_depth();
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("refcounted_slot_allocator test passed");
		else
			$display("refcounted_slot_allocator test failed");
		$finish;
	end

endmodule
